>>> rtl/spmf_pkg.sv
// Shared sizes, status codes and operation codes of the strict-priority multi-level queue.
package spmf_pkg;

    localparam int LEVELS        = 4;
    localparam int DEPTH         = 16;
    localparam int PAYLOAD_WIDTH = 16;

    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int RAM_DEPTH = LEVELS << PTR_W;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef enum logic [1:0] {
        ST_PUSHED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_POPPED  = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

endpackage

>>> rtl/spmf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module spmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/strict_priority_multi_fifo_top.sv
// Top level of the strict-priority multi-level queue: control, pointers and entry RAM.
//
// Usage:
// - The input channel (i_valid/o_ready) carries one transaction per operation:
//   a push of i_payload into level i_priority_req, or a pop of the oldest
//   entry of the highest-numbered non-empty level.
// - The output channel (o_valid/i_ready) returns exactly one result per input
//   transaction, in order: status, popped payload, its level and an all-empty
//   flag that reflects the queue after this operation.
// - On input acceptance the counts and pointers update and the entry RAM
//   access is issued, with the result fields held in the middle stage; when
//   the middle stage moves on, the RAM read data goes into the output register.
// - Throughput is one operation per cycle while o_ready is high. Each
//   operation makes at most one access to the entry RAM, either a write or a
//   read, and the level select is a priority encoder over the per-level counts.
// - Reset empties every level by clearing counts and pointers; the entry RAM
//   is not cleared and needs no sweep, since a pop only reads written slots.
// - When the receiver stalls, the output register holds its result, the
//   middle stage fills, and o_ready drops until the output moves again.
// - A push to a full level or to a level beyond the configured count is
//   dropped; a pop with all levels empty reports the empty status.
module strict_priority_multi_fifo_top
    import spmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [1:0]  i_priority_req,
    input  logic [15:0] i_payload,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_payload,
    output logic [1:0]  o_out_level,
    output logic        o_all_empty
);

    logic [PTR_W-1:0] r_head  [LEVELS];
    logic [PTR_W-1:0] n_head  [LEVELS];
    logic [PTR_W-1:0] r_tail  [LEVELS];
    logic [PTR_W-1:0] n_tail  [LEVELS];
    logic [CNT_W-1:0] r_count [LEVELS];
    logic [CNT_W-1:0] n_count [LEVELS];

    // Middle stage: result fields known at acceptance, waiting for RAM data.
    logic             r_s1_valid;
    t_status          r_s1_status;
    logic [LVL_W-1:0] r_s1_level;
    logic             r_s1_all_empty;
    t_status          n_s1_status;
    logic [LVL_W-1:0] n_s1_level;
    logic             n_s1_all_empty;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [15:0]      r_out_payload;
    logic [1:0]       r_out_level;
    logic             r_out_all_empty;

    logic             in_accept;
    logic             out_load;
    logic             s1_move;

    logic [LVL_W-1:0] push_lvl;
    logic             push_in_range;
    logic [LVL_W-1:0] pop_sel;
    logic             any_nonempty;
    logic             counts_zero;
    logic             count_overflow;

    logic                     ram_we;
    logic [RAM_AW-1:0]        ram_waddr;
    logic [PAYLOAD_WIDTH-1:0] ram_wdata;
    logic                     ram_re;
    logic [RAM_AW-1:0]        ram_raddr;
    logic [PAYLOAD_WIDTH-1:0] ram_rdata;

    assign out_load  = !r_out_valid || i_ready;
    assign s1_move   = r_s1_valid && out_load;
    assign o_ready   = !r_s1_valid || out_load;
    assign in_accept = i_valid && o_ready;

    assign push_lvl      = LVL_W'(i_priority_req);
    assign push_in_range = (int'(i_priority_req) < LEVELS);

    // Highest-numbered non-empty level wins.
    always_comb begin
        pop_sel        = '0;
        any_nonempty   = 1'b0;
        count_overflow = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_count[i] != '0) begin
                pop_sel      = LVL_W'(i);
                any_nonempty = 1'b1;
            end
            if (int'(r_count[i]) > DEPTH) begin
                count_overflow = 1'b1;
            end
        end
    end

    assign counts_zero = !any_nonempty;

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_s1_status    = ST_EMPTY;
        n_s1_level     = '0;
        n_s1_all_empty = 1'b1;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = {push_lvl, r_tail[push_lvl]};
        ram_wdata      = PAYLOAD_WIDTH'(i_payload);
        ram_raddr      = {pop_sel, r_head[pop_sel]};

        if (in_accept) begin
            if (i_operation == OP_PUSH) begin
                if (!push_in_range || int'(r_count[push_lvl]) >= DEPTH) begin
                    n_s1_status = ST_DROPPED;
                end else begin
                    ram_we            = 1'b1;
                    n_tail[push_lvl]  = (r_tail[push_lvl] == PTR_W'(DEPTH - 1)) ?
                                        '0 : r_tail[push_lvl] + 1'b1;
                    n_count[push_lvl] = r_count[push_lvl] + 1'b1;
                    n_s1_status       = ST_PUSHED;
                end
            end else if (any_nonempty) begin
                ram_re           = 1'b1;
                n_head[pop_sel]  = (r_head[pop_sel] == PTR_W'(DEPTH - 1)) ?
                                   '0 : r_head[pop_sel] + 1'b1;
                n_count[pop_sel] = r_count[pop_sel] - 1'b1;
                n_s1_status      = ST_POPPED;
                n_s1_level       = pop_sel;
            end
        end

        for (int i = 0; i < LEVELS; i++) begin
            if (n_count[i] != '0) begin
                n_s1_all_empty = 1'b0;
            end
        end
    end

    spmf_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (o_ready) begin
                r_s1_valid <= in_accept;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_status    <= n_s1_status;
            r_s1_level     <= n_s1_level;
            r_s1_all_empty <= n_s1_all_empty;
        end
        if (s1_move) begin
            r_out_status    <= r_s1_status;
            r_out_payload   <= (r_s1_status == ST_POPPED) ? 16'(ram_rdata) : 16'd0;
            r_out_level     <= 2'(r_s1_level);
            r_out_all_empty <= r_s1_all_empty;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_payload = r_out_payload;
    assign o_out_level   = r_out_level;
    assign o_all_empty   = r_out_all_empty;

    a_pop_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_operation == OP_POP && counts_zero |=> r_s1_status == ST_EMPTY)
        else $error("pop with every level empty did not report the empty status");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !count_overflow)
        else $error("a level count exceeds the level depth");

    a_rdata_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> $stable(ram_rdata))
        else $error("entry RAM read data changed while its result was stalled");

    a_no_payload_unless_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_POPPED |-> o_out_payload == 16'd0 && o_out_level == 2'd0)
        else $error("non-pop result carries a payload or level");

endmodule
